FILE: rtl/acbd_pkg.sv
package acbd_pkg;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    logic        chain_start;
  } in_item_t;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEXP,
    ST_ROUND,
    ST_DONE
  } state_t;

  localparam logic [4:0] REG_KEY_HIGH = 5'h00;
  localparam logic [4:0] REG_KEY_LOW  = 5'h08;
  localparam logic [4:0] REG_IV_HIGH  = 5'h10;
  localparam logic [4:0] REG_IV_LOW   = 5'h18;

  localparam logic [63:0] IV_RESET_HIGH = 64'h0203040506070809;
  localparam logic [63:0] IV_RESET_LOW  = 64'h0A0B0C0D0E0F1011;

  localparam int NUM_ROUNDS = 10;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;      // capture input block, add last round key
    logic       kexp_init; // restart key expansion from key registers
    logic       kexp_step; // produce next round key
    logic       round;     // one inverse round
    logic       last;      // final round, no column mixing
    logic [3:0] rnd;       // round key index used this cycle
  } dp_cmd_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sub_byte(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
      8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
      8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
      8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
      8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
      8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
      8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
      8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
      8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
      8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
      8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
      8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
      8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
      8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
      8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return a[7] ? ((a << 1) ^ 8'h1B) : (a << 1);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] i);
    logic [7:0] r;
    unique case (i)
      4'd1: r = 8'h01;
      4'd2: r = 8'h02;
      4'd3: r = 8'h04;
      4'd4: r = 8'h08;
      4'd5: r = 8'h10;
      4'd6: r = 8'h20;
      4'd7: r = 8'h40;
      4'd8: r = 8'h80;
      4'd9: r = 8'h1B;
      4'd10: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/aes128_cbc_decrypt_core.sv
// aes-128 cbc decryption, one 128-bit block per request
// out_valid rises once the 10 inverse rounds that follow the accepting edge are done
// one block at a time: a new block is taken only after accept, 10 rounds and the result
// handshake; the single inverse-round unit, used once per cycle, serves every round
// reset (synchronous, rst_n low): control, key and iv registers reset, chaining restarts
// from the reset iv, then key expansion runs before the first request
module aes128_cbc_decrypt_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  acbd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output acbd_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  import acbd_pkg::*;

  logic [63:0] key_high_r, key_low_r, iv_high_r, iv_low_r;
  logic        wr_en, key_wr;
  dp_cmd_t     cmd;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  // key writes restart key expansion
  assign key_wr = wr_en & ((paddr == REG_KEY_HIGH) | (paddr == REG_KEY_LOW));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      iv_high_r  <= IV_RESET_HIGH;
      iv_low_r   <= IV_RESET_LOW;
    end else if (wr_en) begin
      unique case (paddr)
        REG_KEY_HIGH: key_high_r <= pwdata;
        REG_KEY_LOW:  key_low_r  <= pwdata;
        REG_IV_HIGH:  iv_high_r  <= pwdata;
        REG_IV_LOW:   iv_low_r   <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr)
      REG_KEY_HIGH: prdata = key_high_r;
      REG_KEY_LOW:  prdata = key_low_r;
      REG_IV_HIGH:  prdata = iv_high_r;
      REG_IV_LOW:   prdata = iv_low_r;
      default:      prdata = '0;
    endcase
  end

  acbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_wr    (key_wr),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath: round state, chaining value, round key store
  acbd_datapath u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .in_item   (in_data),
    .key       ({key_high_r, key_low_r}),
    .iv        ({iv_high_r, iv_low_r}),
    .rst_chain (rst_n),
    .result    (out_data)
  );
endmodule

FILE: rtl/acbd_datapath.sv
module acbd_datapath (
  input  logic               clk,
  input  acbd_pkg::dp_cmd_t  cmd,
  input  acbd_pkg::in_item_t in_item,
  input  logic [127:0]       key,
  input  logic [127:0]       iv,
  input  logic               rst_chain,
  output acbd_pkg::out_item_t result
);
  import acbd_pkg::*;

  logic [127:0] rk_mem [11];
  logic [127:0] kexp_r, kexp_nxt;
  logic [3:0]   kidx_r, kidx_nxt;
  logic [127:0] st_r, st_nxt;
  logic [127:0] prev_r, prev_nxt;
  logic [127:0] chain_r, chain_nxt;
  logic [127:0] rk;
  logic [127:0] shifted, mixed, added;
  logic [31:0]  tw;
  logic [7:0]   a0, a1, a2, a3, tsum, b4, b8;

  assign rk = rk_mem[cmd.rnd];

  // next round key from the current one
  always_comb begin
    tw = {sbox(kexp_r[23:16]), sbox(kexp_r[15:8]), sbox(kexp_r[7:0]), sbox(kexp_r[31:24])}
         ^ {rcon(kidx_r + 4'd1), 24'h0};
    kexp_nxt[127:96] = kexp_r[127:96] ^ tw;
    kexp_nxt[95:64]  = kexp_r[95:64] ^ kexp_nxt[127:96];
    kexp_nxt[63:32]  = kexp_r[63:32] ^ kexp_nxt[95:64];
    kexp_nxt[31:0]   = kexp_r[31:0] ^ kexp_nxt[63:32];
    kidx_nxt = kidx_r + 4'd1;
  end

  // inverse shift rows and inverse substitution; byte i at bits 127-8i
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shifted[127 - 8*(4*c+r) -: 8] =
          inv_sub_byte(st_r[127 - 8*(4*((c + 4 - r) % 4) + r) -: 8]);
      end
    end
    added = shifted ^ rk;
    mixed = added;
    for (int c = 0; c < 4; c++) begin
      a0 = added[127 - 32*c -: 8];
      a1 = added[119 - 32*c -: 8];
      a2 = added[111 - 32*c -: 8];
      a3 = added[103 - 32*c -: 8];
      // inverse mixing as a 4x pre-step on opposite byte pairs, then forward mixing
      tsum = a0 ^ a1 ^ a2 ^ a3;
      b4 = xtime(xtime(a0 ^ a2));
      b8 = xtime(xtime(a1 ^ a3));
      mixed[127 - 32*c -: 8] = a0 ^ b4 ^ tsum ^ xtime(a0 ^ b4 ^ a1 ^ b8);
      mixed[119 - 32*c -: 8] = a1 ^ b8 ^ tsum ^ xtime(a1 ^ b8 ^ a2 ^ b4);
      mixed[111 - 32*c -: 8] = a2 ^ b4 ^ tsum ^ xtime(a2 ^ b4 ^ a3 ^ b8);
      mixed[103 - 32*c -: 8] = a3 ^ b8 ^ tsum ^ xtime(a3 ^ b8 ^ a0 ^ b4);
    end
  end

  always_comb begin
    st_nxt    = st_r;
    prev_nxt  = prev_r;
    chain_nxt = chain_r;
    if (cmd.load) begin
      st_nxt    = {in_item.cipher_high, in_item.cipher_low} ^ rk;
      chain_nxt = in_item.chain_start ? iv : prev_r;
      prev_nxt  = {in_item.cipher_high, in_item.cipher_low};
    end else if (cmd.round) begin
      st_nxt = cmd.last ? (added ^ chain_r) : mixed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_chain) begin
      prev_r <= {IV_RESET_HIGH, IV_RESET_LOW};
    end else begin
      prev_r <= prev_nxt;
    end
    st_r    <= st_nxt;
    chain_r <= chain_nxt;
    if (cmd.kexp_init) begin
      kexp_r <= key;
      kidx_r <= 4'd0;
    end else if (cmd.kexp_step) begin
      kexp_r <= kexp_nxt;
      kidx_r <= kidx_nxt;
    end
    if (cmd.kexp_step) begin
      rk_mem[kidx_r] <= kexp_r;
    end
  end

  assign result = out_item_t'(st_r);
endmodule

FILE: rtl/acbd_ctrl.sv
module acbd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              key_wr,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output acbd_pkg::dp_cmd_t cmd
);
  import acbd_pkg::*;

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_KEXP;
      cnt_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_KEXP: begin
        cmd.kexp_step = 1'b1;
        cmd.kexp_init = (cnt_r == 4'd0);
        cmd.kexp_step = (cnt_r != 4'd0);
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(NUM_ROUNDS + 1)) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = 4'd0;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.rnd  = 4'(NUM_ROUNDS);
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = 4'(NUM_ROUNDS - 1);
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        cmd.rnd   = cnt_r;
        cmd.last  = (cnt_r == 4'd0);
        cnt_nxt   = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (key_wr) begin
      state_nxt = ST_KEXP;
      cnt_nxt   = 4'd0;
    end
  end
endmodule

FILE: rtl/acbd_checker.sv
module acbd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input acbd_pkg::out_item_t out_data
);
  import acbd_pkg::*;

  // no new request while a result is pending
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");

  // result holds under stall
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // accepted request is not done in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid && in_stall)
    else $error("result too early");

  // after reset the core is busy with key expansion
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid) else $error("ready during key expansion");
endmodule

bind aes128_cbc_decrypt_core acbd_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
